// ===== rtl/shs_pkg.sv =====
package shs_pkg;

  // word queue between byte packer and compression engine
  localparam int unsigned FIFO_DEPTH = 16;
  localparam int unsigned FIFO_AW    = 4;

  // byte positions inside a 64-byte block, then round and digest word indices
  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [5:0] PAD_END_POS  = 6'd55;
  localparam logic [5:0] LAST_POS     = 6'd63;
  localparam logic [5:0] LAST_LOAD_RD = 6'd15;
  localparam logic [5:0] LAST_ROUND   = 6'd63;
  localparam logic [2:0] LAST_WORD_IX = 3'd7;

  // one message word on its way to the engine
  typedef struct packed {
    logic [31:0] word;
    logic        msg_end;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sm_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sm_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== rtl/shs_front.sv =====
module shs_front
  import shs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_byte_valid,
  input  logic       in_end_of_message,
  input  logic       fifo_full,
  output q_push_t    push
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_PAD80,
    F_PADZ,
    F_PADLEN
  } f_state_t;

  f_state_t    state_r, state_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [23:0] part_r, part_nxt;
  logic [63:0] bits_r, bits_nxt;

  logic       accept;
  logic       put;
  logic [7:0] byte_in;

  // items are taken only between messages' padding and while the queue has room
  assign in_stall = (state_r != F_IDLE) || fifo_full;
  assign accept   = in_valid && !in_stall;

  // byte source: message byte, pad marker, zero fill or length byte
  always_comb begin
    put     = 1'b0;
    byte_in = in_byte_value;
    case (state_r)
      F_IDLE: begin
        put     = accept && in_byte_valid;
        byte_in = in_byte_value;
      end
      F_PAD80: begin
        put     = !fifo_full;
        byte_in = PAD_BYTE;
      end
      F_PADZ: begin
        put     = !fifo_full;
        byte_in = 8'h00;
      end
      F_PADLEN: begin
        put     = !fifo_full;
        byte_in = bits_r[{~pos_r[2:0], 3'b000} +: 8];
      end
      default: begin
        put     = 1'b0;
        byte_in = 8'h00;
      end
    endcase
  end

  // a word goes to the queue with every fourth byte
  assign push.valid         = put && (pos_r[1:0] == 2'b11);
  assign push.entry.word    = {part_r, byte_in};
  assign push.entry.msg_end = (state_r == F_PADLEN) && (pos_r == LAST_POS);

  // padding sequencer and bit count
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = put ? pos_r + 6'd1 : pos_r;
    part_nxt  = put ? {part_r[15:0], byte_in} : part_r;
    bits_nxt  = bits_r;
    case (state_r)
      F_IDLE: begin
        if (accept && in_byte_valid) bits_nxt = bits_r + 64'd8;
        if (accept && in_end_of_message) state_nxt = F_PAD80;
      end
      F_PAD80: begin
        if (put) state_nxt = (pos_r == PAD_END_POS) ? F_PADLEN : F_PADZ;
      end
      F_PADZ: begin
        if (put && (pos_r == PAD_END_POS)) state_nxt = F_PADLEN;
      end
      F_PADLEN: begin
        if (put && (pos_r == LAST_POS)) begin
          state_nxt = F_IDLE;
          bits_nxt  = '0;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      pos_r   <= '0;
      bits_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      bits_r  <= bits_nxt;
    end
    part_r <= part_nxt;
  end

endmodule

// ===== rtl/shs_fifo.sv =====
module shs_fifo
  import shs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  q_push_t  push,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r;
  logic [FIFO_AW-1:0]   rd_ptr_r;
  logic [FIFO_AW:0]     count_r;

  assign full       = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.entry;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push.valid, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/shs_core.sv =====
module shs_core
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  q_entry_t    head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [1:0] {
    C_ROUND,
    C_FOLD,
    C_EMIT
  } c_state_t;

  c_state_t    state_r;
  logic [5:0]  round_r;
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [31:0] w_r [16];
  logic        final_r;
  logic [2:0]  emit_idx_r;
  logic        out_valid_r;
  logic [31:0] out_digest_word_r;
  logic [2:0]  out_word_index_r;
  logic        out_last_word_r;

  logic        load_rd;
  logic        go;
  logic        emit_go;
  logic [31:0] w_calc;
  logic [31:0] w_cur;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  // message schedule: first 16 words from the queue, the rest expanded
  assign load_rd = (round_r[5:4] == 2'b00);
  assign w_calc  = sm_sig1(w_r[14]) + w_r[9] + sm_sig0(w_r[1]) + w_r[0];
  assign w_cur   = load_rd ? head.word : w_calc;

  assign go      = (state_r == C_ROUND) && (!load_rd || head_valid);
  assign pop     = go && load_rd;
  assign emit_go = (state_r == C_EMIT) && (!out_valid_r || !out_stall);

  // one compression round
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + big_sig1(v_r[4]) + ch + ROUND_K[round_r] + w_cur;
  assign t2  = big_sig0(v_r[0]) + maj;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_ROUND;
      round_r     <= '0;
      final_r     <= 1'b0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= INIT_H[i];
        v_r[i] <= INIT_H[i];
      end
    end else begin
      if (out_valid_r && !out_stall && !emit_go) out_valid_r <= 1'b0;
      case (state_r)
        // rounds, one per cycle while the queue holds the words the first 16 need
        C_ROUND: begin
          if (go) begin
            v_r[0] <= t1 + t2;
            v_r[1] <= v_r[0];
            v_r[2] <= v_r[1];
            v_r[3] <= v_r[2];
            v_r[4] <= v_r[3] + t1;
            v_r[5] <= v_r[4];
            v_r[6] <= v_r[5];
            v_r[7] <= v_r[6];
            for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
            w_r[15] <= w_cur;
            if (round_r == LAST_LOAD_RD) final_r <= head.msg_end;
            round_r <= round_r + 6'd1;
            if (round_r == LAST_ROUND) state_r <= C_FOLD;
          end
        end
        // add the working variables into the chaining value
        C_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + v_r[i];
            v_r[i] <= h_r[i] + v_r[i];
          end
          emit_idx_r <= '0;
          state_r    <= final_r ? C_EMIT : C_ROUND;
        end
        // digest out, then back to the initial hash values
        C_EMIT: begin
          if (emit_go) begin
            out_valid_r       <= 1'b1;
            out_digest_word_r <= h_r[emit_idx_r];
            out_word_index_r  <= emit_idx_r;
            out_last_word_r   <= (emit_idx_r == LAST_WORD_IX);
            emit_idx_r        <= emit_idx_r + 3'd1;
            if (emit_idx_r == LAST_WORD_IX) begin
              state_r <= C_ROUND;
              for (int i = 0; i < 8; i++) begin
                h_r[i] <= INIT_H[i];
                v_r[i] <= INIT_H[i];
              end
            end
          end
        end
        default: state_r <= C_ROUND;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_digest_word_r;
  assign out_word_index  = out_word_index_r;
  assign out_last_word   = out_last_word_r;

endmodule

// ===== rtl/sha256_stream_hasher_top.sv =====
// SHA-256 hasher fed one byte per item. Message bytes are taken one per cycle,
// while the queue has room and no padding is under way, into a 16-word queue;
// the compression engine behind it runs one round per cycle while the queue
// holds the words it needs, so each 64-byte block takes 64 rounds and one fold
// into the chaining value, and a long message streams at a rate set by the
// round loop. The end-of-message item is followed by up to 72 padding bytes,
// generated one per cycle while the queue has room (in_stall high throughout),
// then the final one or two blocks and eight digest words, H0 first with
// out_last_word on H7. After the last digest word the engine restarts from the
// initial hash values; bytes of the next message may be queued meanwhile.
module sha256_stream_hasher_top
  import shs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  q_push_t  push;
  q_entry_t head;
  logic     fifo_full;
  logic     head_valid;
  logic     pop;

  // byte packer and padding
  shs_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_value     (in_byte_value),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .fifo_full         (fifo_full),
    .push              (push)
  );

  // word queue
  shs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .full       (fifo_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // compression engine and digest output
  shs_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

`ifndef SYNTHESIS
  // packer never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !fifo_full)
    else $error("word pushed into full queue");

  // end of message starts padding, so the next cycle takes no item
  a_pad_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_end_of_message) |=> in_stall)
    else $error("item taken right after end of message");

  // digest words follow each other without a gap once one is taken
  a_digest_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=> out_valid)
    else $error("gap inside digest burst");
`endif

endmodule
